/* sv/padc_pkg.sv */
// ----------------------------------------------------------------------------
// padc_pkg: shared types and constants for the parallel ADC capture block
// Read-sequence phases, configuration register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package padc_pkg;

	// parameter defaults
	localparam int unsigned DEF_CHANNELS         = 5;
	localparam int unsigned DEF_SLOTS_PER_BUFFER = 1024;
	localparam int unsigned DEF_BUFFER_COUNT     = 3;
	localparam int unsigned DEF_MIN_PERIOD_TICKS = 64;

	// fixed widths of the transaction fields
	localparam int unsigned CHAN_OUT_W  = 3;
	localparam int unsigned BUF_OUT_W   = 2;
	localparam int unsigned SLOT_OUT_W  = 10;
	localparam int unsigned FLAGS_OUT_W = 3;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned BUS_W       = 16;
	localparam int unsigned STROBE_W    = 4;
	localparam int unsigned CFG_IDX_W   = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RD_LOW        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RD_HIGH       = 2'd2;

	// configuration reset values
	localparam logic [WORD_W-1:0]   RST_SAMPLE_PERIOD = 32'd1000;
	localparam logic [STROBE_W-1:0] RST_RD_LOW        = 4'd2;
	localparam logic [STROBE_W-1:0] RST_RD_HIGH       = 4'd1;

	// read sequence phases
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_CONV    = 3'd1,
		PH_RD_LOW  = 3'd2,
		PH_RD_HIGH = 3'd3,
		PH_CLOSE   = 3'd4
	} phase_t;

endpackage

/* sv/parallel_adc_multichannel_capture.sv */
// ----------------------------------------------------------------------------
// parallel_adc_multichannel_capture: parallel ADC capture controller
// Drives CONVST, CS and RD for a multichannel parallel-bus ADC, timestamps
// each conversion and issues store writes into a rotating set of buffers.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       to block   in_valid / in_stall   run, busy_req, bus_data
//  out      from block out_valid / out_stall convst .. buffers_completed
//  cfg      to block   cfg_wr_en             cfg_index, cfg_data
//
//  One input transaction is one controller tick and yields one output
//  transaction; a new tick is taken every cycle while in_stall is low.
//  The next state and the result are formed in one pass
//  from the state registers and land in the output register.
//  in_stall is high only while the output register holds an untaken result.
//  Reset returns the controller state and out_valid to their reset values; configuration returns to its defaults.
// ----------------------------------------------------------------------------
module parallel_adc_multichannel_capture
	import padc_pkg::*;
#(
	parameter int unsigned CHANNELS         = DEF_CHANNELS,
	parameter int unsigned SLOTS_PER_BUFFER = DEF_SLOTS_PER_BUFFER,
	parameter int unsigned BUFFER_COUNT     = DEF_BUFFER_COUNT,
	parameter int unsigned MIN_PERIOD_TICKS = DEF_MIN_PERIOD_TICKS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [WORD_W-1:0]      cfg_data,
	// input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   run,
	input  logic                   busy_req,
	input  logic [BUS_W-1:0]       bus_data,
	// output channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   convst,
	output logic                   cs_n,
	output logic                   rd_n,
	output logic                   wr_valid,
	output logic [CHAN_OUT_W-1:0]  wr_channel,
	output logic [BUF_OUT_W-1:0]   wr_buffer,
	output logic [SLOT_OUT_W-1:0]  wr_slot,
	output logic [WORD_W-1:0]      wr_data,
	output logic [FLAGS_OUT_W-1:0] buffers_full,
	output logic                   buffer_done,
	output logic [WORD_W-1:0]      buffers_completed
);

	localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int unsigned SLOT_W = $clog2(SLOTS_PER_BUFFER);
	localparam int unsigned BUF_W  = $clog2(BUFFER_COUNT);
	localparam logic [WORD_W-1:0] MIN_PERIOD = WORD_W'(MIN_PERIOD_TICKS);
	localparam logic [WORD_W-1:0] RST_EFF_PERIOD =
		(RST_SAMPLE_PERIOD < MIN_PERIOD) ? MIN_PERIOD : RST_SAMPLE_PERIOD;
	localparam logic [CHAN_OUT_W-1:0] TS_CODE  = CHAN_OUT_W'(CHANNELS);
	localparam logic [CH_W-1:0]       LAST_CH  = CH_W'(CHANNELS - 1);
	localparam logic [SLOT_W-1:0]     LAST_SLOT = SLOT_W'(SLOTS_PER_BUFFER - 1);
	localparam logic [BUF_W-1:0]      LAST_BUF = BUF_W'(BUFFER_COUNT - 1);

	// configuration, stored already clamped
	logic [WORD_W-1:0]   eff_period_q;
	logic [STROBE_W-1:0] rd_low_q;
	logic [STROBE_W-1:0] rd_high_q;

	// controller state
	phase_t                  phase_q, phase_n;
	logic [WORD_W-1:0]       period_q, period_n;
	logic [STROBE_W-1:0]     strobe_q, strobe_n;
	logic [CH_W-1:0]         chan_q, chan_n;
	logic [SLOT_W-1:0]       slot_q, slot_n;
	logic [BUF_W-1:0]        buf_q, buf_n;
	logic [BUFFER_COUNT-1:0] flags_q, flags_n;
	logic [WORD_W-1:0]       completed_q, completed_n;
	logic [WORD_W-1:0]       cycle_q;
	logic                    stopped_q, stopped_n;
	logic                    busy_prev_q;
	logic                    run_prev_q;

	// result of this tick
	logic                  res_convst, res_cs_n, res_rd_n, res_wr_valid, res_done;
	logic [CHAN_OUT_W-1:0] res_channel;
	logic [BUF_OUT_W-1:0]  res_buffer;
	logic [SLOT_OUT_W-1:0] res_slot;
	logic [WORD_W-1:0]     res_data;

	// output register
	logic                   out_valid_q;
	logic                   convst_q, cs_n_q, rd_n_q, wr_valid_q, done_q;
	logic [CHAN_OUT_W-1:0]  channel_q;
	logic [BUF_OUT_W-1:0]   buffer_q;
	logic [SLOT_OUT_W-1:0]  slot_out_q;
	logic [WORD_W-1:0]      data_q;
	logic [FLAGS_OUT_W-1:0] flags_out_q;
	logic [WORD_W-1:0]      completed_out_q;

	logic accept;

	// zero-extend then truncate to the fixed field widths
	logic [SLOT_W+SLOT_OUT_W-1:0]        slot_ext;
	logic [BUF_W+BUF_OUT_W-1:0]          buf_ext;
	logic [BUFFER_COUNT+FLAGS_OUT_W-1:0] flags_ext;

	assign slot_ext  = {{SLOT_OUT_W{1'b0}}, slot_q};
	assign buf_ext   = {{BUF_OUT_W{1'b0}}, buf_q};
	assign flags_ext = {{FLAGS_OUT_W{1'b0}}, flags_n};

	// handshake
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_period_q <= RST_EFF_PERIOD;
			rd_low_q     <= RST_RD_LOW;
			rd_high_q    <= RST_RD_HIGH;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SAMPLE_PERIOD: eff_period_q <= (cfg_data < MIN_PERIOD) ? MIN_PERIOD : cfg_data;
				REG_RD_LOW: rd_low_q <= (cfg_data[STROBE_W-1:0] == '0) ?
					STROBE_W'(1) : cfg_data[STROBE_W-1:0];
				REG_RD_HIGH: rd_high_q <= (cfg_data[STROBE_W-1:0] == '0) ?
					STROBE_W'(1) : cfg_data[STROBE_W-1:0];
				default: ;
			endcase
		end
	end

	// next state and result of one tick
	always_comb begin
		logic                       fall;
		logic                       rise;
		logic                       expire;
		logic [WORD_W:0]            period_inc;
		logic [STROBE_W-1:0]        strobe_inc;
		logic [BUF_W-1:0]           buf_next;
		logic [CH_W+CHAN_OUT_W-1:0] chan_wide;

		fall       = busy_prev_q & ~busy_req;
		rise       = run & ~run_prev_q;
		period_inc = {1'b0, period_q} + (WORD_W+1)'(1);
		expire     = period_inc >= {1'b0, eff_period_q};
		buf_next   = (buf_q == LAST_BUF) ? '0 : buf_q + BUF_W'(1);
		strobe_inc = '0;
		chan_wide  = '0;

		phase_n     = phase_q;
		period_n    = period_q;
		strobe_n    = strobe_q;
		chan_n      = chan_q;
		slot_n      = slot_q;
		buf_n       = buf_q;
		flags_n     = flags_q;
		completed_n = completed_q;
		stopped_n   = stopped_q;

		res_convst   = 1'b0;
		res_cs_n     = 1'b1;
		res_rd_n     = 1'b1;
		res_wr_valid = 1'b0;
		res_done     = 1'b0;
		res_channel  = '0;
		res_buffer   = '0;
		res_slot     = '0;
		res_data     = '0;

		if (!run) begin
			// stopped: abort any read, keep indices
			stopped_n = 1'b1;
			phase_n   = PH_IDLE;
			strobe_n  = '0;
			chan_n    = '0;
		end else if (rise) begin
			// restart: clear indices, keep full flags
			stopped_n   = 1'b0;
			phase_n     = PH_IDLE;
			slot_n      = '0;
			buf_n       = '0;
			completed_n = '0;
			period_n    = '0;
			strobe_n    = '0;
			chan_n      = '0;
		end else begin
			period_n = expire ? '0 : period_inc[WORD_W-1:0];
			// end of conversion starts the read burst
			if (phase_q == PH_CONV && fall) begin
				phase_n  = PH_RD_LOW;
				strobe_n = '0;
				chan_n   = '0;
			end
			strobe_inc = strobe_n + STROBE_W'(1);
			case (phase_n)
				PH_IDLE, PH_CONV: begin
					if (expire && !stopped_q) begin
						phase_n      = PH_CONV;
						res_wr_valid = 1'b1;
						res_channel  = TS_CODE;
						res_buffer   = buf_ext[BUF_OUT_W-1:0];
						res_slot     = slot_ext[SLOT_OUT_W-1:0];
						res_data     = cycle_q;
					end
					res_convst = (phase_n == PH_CONV);
				end
				PH_RD_LOW: begin
					res_cs_n = 1'b0;
					res_rd_n = 1'b0;
					strobe_n = strobe_inc;
					if (strobe_inc >= rd_low_q) begin
						chan_wide    = {{CHAN_OUT_W{1'b0}}, chan_n};
						res_wr_valid = 1'b1;
						res_channel  = chan_wide[CHAN_OUT_W-1:0];
						res_buffer   = buf_ext[BUF_OUT_W-1:0];
						res_slot     = slot_ext[SLOT_OUT_W-1:0];
						res_data     = WORD_W'(bus_data);
						strobe_n     = '0;
						phase_n      = (chan_n == LAST_CH) ? PH_CLOSE : PH_RD_HIGH;
					end
				end
				PH_RD_HIGH: begin
					res_cs_n = 1'b0;
					strobe_n = strobe_inc;
					if (strobe_inc >= rd_high_q) begin
						strobe_n = '0;
						chan_n   = chan_n + CH_W'(1);
						phase_n  = PH_RD_LOW;
					end
				end
				PH_CLOSE: begin
					// advance slot, rotate buffer when full
					if (slot_q == LAST_SLOT) begin
						slot_n            = '0;
						flags_n[buf_q]    = 1'b1;
						flags_n[buf_next] = 1'b0;
						buf_n             = buf_next;
						completed_n       = completed_q + WORD_W'(1);
						res_done          = 1'b1;
					end else begin
						slot_n = slot_q + SLOT_W'(1);
					end
					chan_n  = '0;
					phase_n = PH_IDLE;
				end
				default: phase_n = PH_IDLE;
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			period_q    <= '0;
			strobe_q    <= '0;
			chan_q      <= '0;
			slot_q      <= '0;
			buf_q       <= '0;
			flags_q     <= '0;
			completed_q <= '0;
			cycle_q     <= '0;
			stopped_q   <= 1'b1;
			busy_prev_q <= 1'b0;
			run_prev_q  <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_n;
			period_q    <= period_n;
			strobe_q    <= strobe_n;
			chan_q      <= chan_n;
			slot_q      <= slot_n;
			buf_q       <= buf_n;
			flags_q     <= flags_n;
			completed_q <= completed_n;
			cycle_q     <= cycle_q + WORD_W'(1);
			stopped_q   <= stopped_n;
			busy_prev_q <= busy_req;
			run_prev_q  <= run;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			convst_q        <= res_convst;
			cs_n_q          <= res_cs_n;
			rd_n_q          <= res_rd_n;
			wr_valid_q      <= res_wr_valid;
			channel_q       <= res_channel;
			buffer_q        <= res_buffer;
			slot_out_q      <= res_slot;
			data_q          <= res_data;
			flags_out_q     <= flags_ext[FLAGS_OUT_W-1:0];
			done_q          <= res_done;
			completed_out_q <= completed_n;
		end
	end

	assign out_valid         = out_valid_q;
	assign convst            = convst_q;
	assign cs_n              = cs_n_q;
	assign rd_n              = rd_n_q;
	assign wr_valid          = wr_valid_q;
	assign wr_channel        = channel_q;
	assign wr_buffer         = buffer_q;
	assign wr_slot           = slot_out_q;
	assign wr_data           = data_q;
	assign buffers_full      = flags_out_q;
	assign buffer_done       = done_q;
	assign buffers_completed = completed_out_q;

	// read strobe only inside chip select
	a_rd_in_cs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rd_n_q |-> !cs_n_q)
		else $error("read strobe low outside chip select");

	// conversion start and read burst never overlap
	a_convst_no_cs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(convst_q && !cs_n_q))
		else $error("convst high during read burst");

	// a write outside the read burst is a timestamp and comes with convst
	a_stamp_convst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && wr_valid_q && cs_n_q |-> convst_q)
		else $error("timestamp write without convst");

	// buffer completion happens on the closing tick, bus released, no write
	a_done_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> !wr_valid_q && cs_n_q && !convst_q)
		else $error("buffer completion on a busy tick");

	// after a tick with run low the sequencer sits idle
	a_stop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!run_prev_q |-> phase_q == PH_IDLE)
		else $error("sequencer active while stopped");

endmodule

/* tb/sv/padc_capture_checker.sv */
// ----------------------------------------------------------------------------
// padc_capture_checker: tick predictor and result checker for the ADC capture
// Watches the register port and both channels. Each input transaction is
// replayed through a cycle model of the capture controller. The predicted pin
// levels and store writes are queued. Each output transaction is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module padc_capture_checker
	import padc_pkg::*;
#(
	parameter int unsigned CHANNELS         = DEF_CHANNELS,
	parameter int unsigned SLOTS_PER_BUFFER = DEF_SLOTS_PER_BUFFER,
	parameter int unsigned BUFFER_COUNT     = DEF_BUFFER_COUNT,
	parameter int unsigned MIN_PERIOD_TICKS = DEF_MIN_PERIOD_TICKS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [WORD_W-1:0]      cfg_data,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic                   run,
	input  logic                   busy_req,
	input  logic [BUS_W-1:0]       bus_data,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic                   convst,
	input  logic                   cs_n,
	input  logic                   rd_n,
	input  logic                   wr_valid,
	input  logic [CHAN_OUT_W-1:0]  wr_channel,
	input  logic [BUF_OUT_W-1:0]   wr_buffer,
	input  logic [SLOT_OUT_W-1:0]  wr_slot,
	input  logic [WORD_W-1:0]      wr_data,
	input  logic [FLAGS_OUT_W-1:0] buffers_full,
	input  logic                   buffer_done,
	input  logic [WORD_W-1:0]      buffers_completed,
	output int                     mismatches,
	output int                     pending,
	output int                     ticks_checked,
	output int                     store_writes,
	output int                     completions
);

	typedef struct packed {
		logic                   convst;
		logic                   cs_n;
		logic                   rd_n;
		logic                   wr_valid;
		logic [CHAN_OUT_W-1:0]  wr_channel;
		logic [BUF_OUT_W-1:0]   wr_buffer;
		logic [SLOT_OUT_W-1:0]  wr_slot;
		logic [WORD_W-1:0]      wr_data;
		logic [FLAGS_OUT_W-1:0] buffers_full;
		logic                   buffer_done;
		logic [WORD_W-1:0]      buffers_completed;
	} tick_outputs_t;

	tick_outputs_t expected_q[$];

	// register copies
	logic [WORD_W-1:0]   period_cfg;
	logic [STROBE_W-1:0] rd_low_cfg;
	logic [STROBE_W-1:0] rd_high_cfg;

	// controller state
	phase_t              seq_phase;
	logic [WORD_W-1:0]   period_cnt;
	logic [STROBE_W-1:0] strobe_cnt;
	logic [2:0]          chan_idx;
	int unsigned         slot_idx;
	int unsigned         buf_idx;
	logic [7:0]          full_mask;
	logic [WORD_W-1:0]   done_total;
	logic [WORD_W-1:0]   tick_count;
	logic                halted;
	logic                busy_q;
	logic                run_q;

	// advance the controller by one tick and return its pin levels and write
	function automatic tick_outputs_t predict_tick(logic run_in, logic busy_in,
			logic [BUS_W-1:0] word);
		tick_outputs_t res;
		logic [WORD_W-1:0]   stamp;
		logic [WORD_W-1:0]   span;
		logic [STROBE_W-1:0] low_len;
		logic [STROBE_W-1:0] high_len;
		logic                busy_fall;
		logic                run_rise;
		logic                expire;

		stamp     = tick_count;
		busy_fall = busy_q && !busy_in;
		run_rise  = run_in && !run_q;
		span      = (period_cfg < MIN_PERIOD_TICKS) ? WORD_W'(MIN_PERIOD_TICKS) : period_cfg;
		low_len   = (rd_low_cfg == '0) ? STROBE_W'(1) : rd_low_cfg;
		high_len  = (rd_high_cfg == '0) ? STROBE_W'(1) : rd_high_cfg;
		expire    = 1'b0;
		res       = '0;
		res.cs_n  = 1'b1;
		res.rd_n  = 1'b1;

		tick_count = tick_count + WORD_W'(1);
		busy_q     = busy_in;
		run_q      = run_in;

		if (!run_in) begin
			// stopped: abort any read, keep indices
			halted     = 1'b1;
			seq_phase  = PH_IDLE;
			strobe_cnt = '0;
			chan_idx   = '0;
		end else if (run_rise) begin
			// restart: clear indices and count, keep full flags
			halted     = 1'b0;
			seq_phase  = PH_IDLE;
			slot_idx   = 0;
			buf_idx    = 0;
			done_total = '0;
			period_cnt = '0;
			strobe_cnt = '0;
			chan_idx   = '0;
		end else begin
			period_cnt = period_cnt + WORD_W'(1);
			if (period_cnt >= span) begin
				expire     = 1'b1;
				period_cnt = '0;
			end
			// only a started conversion is read out
			if (seq_phase == PH_CONV && busy_fall) begin
				seq_phase  = PH_RD_LOW;
				strobe_cnt = '0;
				chan_idx   = '0;
			end
			case (seq_phase)
				PH_IDLE, PH_CONV: begin
					if (expire && !halted) begin
						seq_phase      = PH_CONV;
						res.wr_valid   = 1'b1;
						res.wr_channel = CHAN_OUT_W'(CHANNELS);
						res.wr_buffer  = BUF_OUT_W'(buf_idx);
						res.wr_slot    = SLOT_OUT_W'(slot_idx);
						res.wr_data    = stamp;
					end
					res.convst = (seq_phase == PH_CONV);
				end
				PH_RD_LOW: begin
					res.cs_n   = 1'b0;
					res.rd_n   = 1'b0;
					strobe_cnt = strobe_cnt + STROBE_W'(1);
					if (strobe_cnt >= low_len) begin
						res.wr_valid   = 1'b1;
						res.wr_channel = chan_idx;
						res.wr_buffer  = BUF_OUT_W'(buf_idx);
						res.wr_slot    = SLOT_OUT_W'(slot_idx);
						res.wr_data    = WORD_W'(word);
						strobe_cnt     = '0;
						if (int'(chan_idx) + 1 < CHANNELS) seq_phase = PH_RD_HIGH;
						else seq_phase = PH_CLOSE;
					end
				end
				PH_RD_HIGH: begin
					res.cs_n   = 1'b0;
					strobe_cnt = strobe_cnt + STROBE_W'(1);
					if (strobe_cnt >= high_len) begin
						strobe_cnt = '0;
						chan_idx   = chan_idx + 3'(1);
						seq_phase  = PH_RD_LOW;
					end
				end
				PH_CLOSE: begin
					// next slot, rotate buffers when one fills
					slot_idx = slot_idx + 1;
					if (slot_idx >= SLOTS_PER_BUFFER) begin
						slot_idx        = 0;
						full_mask       = full_mask | (8'd1 << buf_idx[2:0]);
						buf_idx         = (buf_idx + 1) % BUFFER_COUNT;
						full_mask       = full_mask & ~(8'd1 << buf_idx[2:0]);
						done_total      = done_total + WORD_W'(1);
						res.buffer_done = 1'b1;
					end
					chan_idx  = '0;
					seq_phase = PH_IDLE;
				end
				default: seq_phase = PH_IDLE;
			endcase
		end

		res.buffers_full      = full_mask[FLAGS_OUT_W-1:0];
		res.buffers_completed = done_total;
		return res;
	endfunction

	function automatic void check_field(string field, logic [WORD_W-1:0] want,
			logic [WORD_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$error("tick %0d %s: expected 0x%0h, got 0x%0h",
				ticks_checked, field, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tick_outputs_t want;
		if (!arst_n) begin
			period_cfg    = RST_SAMPLE_PERIOD;
			rd_low_cfg    = RST_RD_LOW;
			rd_high_cfg   = RST_RD_HIGH;
			seq_phase     = PH_IDLE;
			period_cnt    = '0;
			strobe_cnt    = '0;
			chan_idx      = '0;
			slot_idx      = 0;
			buf_idx       = 0;
			full_mask     = '0;
			done_total    = '0;
			tick_count    = '0;
			halted        = 1'b1;
			busy_q        = 1'b0;
			run_q         = 1'b0;
			mismatches    = 0;
			ticks_checked = 0;
			store_writes  = 0;
			completions   = 0;
			expected_q.delete();
			pending       = 0;
		end else begin
			// register writes
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_SAMPLE_PERIOD: period_cfg  = cfg_data;
					REG_RD_LOW:        rd_low_cfg  = cfg_data[STROBE_W-1:0];
					REG_RD_HIGH:       rd_high_cfg = cfg_data[STROBE_W-1:0];
					default: ;
				endcase
			end
			// output transaction against the oldest prediction
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					$error("output transaction with no tick waiting for it");
				end else begin
					want = expected_q.pop_front();
					check_field("convst", want.convst, convst);
					check_field("cs_n", want.cs_n, cs_n);
					check_field("rd_n", want.rd_n, rd_n);
					check_field("wr_valid", want.wr_valid, wr_valid);
					check_field("wr_channel", want.wr_channel, wr_channel);
					check_field("wr_buffer", want.wr_buffer, wr_buffer);
					check_field("wr_slot", want.wr_slot, wr_slot);
					check_field("wr_data", want.wr_data, wr_data);
					check_field("buffers_full", want.buffers_full, buffers_full);
					check_field("buffer_done", want.buffer_done, buffer_done);
					check_field("buffers_completed", want.buffers_completed, buffers_completed);
					ticks_checked++;
					if (want.wr_valid) store_writes++;
					if (want.buffer_done) completions++;
				end
			end
			// input transaction: one controller tick
			if (in_valid && !in_stall)
				expected_q.push_back(predict_tick(run, busy_req, bus_data));
			pending = expected_q.size();
		end
	end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for parallel_adc_multichannel_capture
// Drives ticks of run, busy and bus data with random gaps and output stalls
// over several register settings, then a gap-free tail at the shortest
// period. Prediction and comparison live in the checker.
// ----------------------------------------------------------------------------
module testbench
	import padc_pkg::*;
();

	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int LONG_HOLD_CYCLES = 60;
	localparam int HAUL_TICKS       = 100;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [WORD_W-1:0]      cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic                   run;
	logic                   busy_req;
	logic [BUS_W-1:0]       bus_data;
	logic                   out_valid;
	logic                   out_stall;
	logic                   convst;
	logic                   cs_n;
	logic                   rd_n;
	logic                   wr_valid;
	logic [CHAN_OUT_W-1:0]  wr_channel;
	logic [BUF_OUT_W-1:0]   wr_buffer;
	logic [SLOT_OUT_W-1:0]  wr_slot;
	logic [WORD_W-1:0]      wr_data;
	logic [FLAGS_OUT_W-1:0] buffers_full;
	logic                   buffer_done;
	logic [WORD_W-1:0]      buffers_completed;

	int mismatches;
	int pending;
	int ticks_checked;
	int store_writes;
	int completions;

	// stimulus state shared by the driving processes
	bit   quiet_tail;
	bit   long_hold_req;
	logic run_level;
	logic busy_level;
	int   busy_left;
	int   sender_calm;
	int   settings_used;

	parallel_adc_multichannel_capture dut (.*);

	padc_capture_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// wait until every predicted tick has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// strobe registers get random upper bits, only the low nibble counts
	task automatic configure(input logic [WORD_W-1:0] period,
			input logic [STROBE_W-1:0] low_len, input logic [STROBE_W-1:0] high_len);
		logic [WORD_W-1:0] word;
		write_reg(REG_SAMPLE_PERIOD, period);
		word = $urandom();
		word[STROBE_W-1:0] = low_len;
		write_reg(REG_RD_LOW, word);
		word = $urandom();
		word[STROBE_W-1:0] = high_len;
		write_reg(REG_RD_HIGH, word);
		settings_used++;
	endtask

	// one input transaction, with a random gap in front of it
	task automatic send_tick(input logic r, input logic b, input logic [BUS_W-1:0] d);
		if (!quiet_tail) begin
			if (sender_calm > 0) sender_calm--;
			else if ($urandom_range(0, 19) == 0) sender_calm = $urandom_range(20, 80);
			else if ($urandom_range(0, 5) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
		end
		in_valid <= 1'b1;
		run      <= r;
		busy_req <= b;
		bus_data <= d;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// busy behaves like a converter most of the time, with some noise
	task automatic run_phase(input int n_ticks, input int noise_pct, input int stop_permille,
			input int busy_max);
		logic             b;
		logic [BUS_W-1:0] d;
		for (int i = 0; i < n_ticks; i++) begin
			if (run_level ? ($urandom_range(0, 999) < stop_permille) : ($urandom_range(0, 3) == 0))
				run_level = ~run_level;
			if (busy_left == 0) begin
				busy_level = ~busy_level;
				busy_left  = $urandom_range(1, busy_max);
			end
			busy_left--;
			if ($urandom_range(0, 99) < noise_pct) b = 1'($urandom_range(0, 1));
			else b = busy_level;
			case ($urandom_range(0, 9))
				0:       d = '0;
				1:       d = '1;
				default: d = BUS_W'($urandom_range(0, 16'hFFFF));
			endcase
			send_tick(run_level, b, d);
		end
	endtask

	// receiver: random stall bursts, calm stretches and one long hold-off
	initial begin : receiver
		int stall_left;
		int calm_left;
		stall_left = 0;
		calm_left  = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left    = LONG_HOLD_CYCLES;
			end else if (stall_left == 0 && !quiet_tail) begin
				if (calm_left > 0) calm_left--;
				else if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 80);
				else if ($urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 9);
			end
			out_stall <= (stall_left != 0);
			if (stall_left != 0) stall_left--;
		end
	end

	// ends the run when no transaction moves for too long
	initial begin : watchdog
		int still_cycles;
		still_cycles = 0;
		while (still_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
				still_cycles = 0;
			else
				still_cycles++;
		end
		$display("** parallel_adc_multichannel_capture: FAILED **");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = REG_SAMPLE_PERIOD;
		cfg_data      = '0;
		in_valid      = 1'b0;
		run           = 1'b0;
		busy_req      = 1'b0;
		bus_data      = '0;
		quiet_tail    = 1'b0;
		long_hold_req = 1'b0;
		run_level     = 1'b0;
		busy_level    = 1'b0;
		busy_left     = 0;
		sender_calm   = 0;
		settings_used = 1;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: stopped ticks, run edges, busy falling while idle, bus extremes
		send_tick(1'b0, 1'b1, 16'hFFFF);
		send_tick(1'b0, 1'b0, 16'h0000);
		send_tick(1'b1, 1'b1, 16'hAAAA);
		send_tick(1'b1, 1'b0, 16'h5555);
		send_tick(1'b1, 1'b1, 16'hFFFF);
		send_tick(1'b1, 1'b1, 16'h0000);
		send_tick(1'b0, 1'b0, 16'h1234);
		send_tick(1'b0, 1'b1, 16'h8001);
		send_tick(1'b1, 1'b1, 16'hFFFF);
		send_tick(1'b1, 1'b0, 16'h0001);
		send_tick(1'b0, 1'b0, 16'h8000);
		send_tick(1'b1, 1'b0, 16'h7FFF);
		run_level = 1'b1;

		// shortest period and strobes, with the long hold and a drain pause
		configure(32'd64, 4'd1, 4'd1);
		run_phase(100, 5, 3, 12);
		long_hold_req = 1'b1;
		run_phase(100, 5, 3, 12);
		wait_drained();
		run_phase(60, 5, 3, 12);

		// period below the minimum, zero low strobe, longest high strobe
		configure(32'd0, 4'd0, 4'd15);
		run_phase(120, 10, 5, 20);

		// reads longer than a period, zero high strobe
		configure(32'd5, 4'd15, 4'd0);
		run_phase(120, 10, 5, 25);

		// period that never expires, noisy run and busy
		configure(32'hFFFF_FFFF, 4'd7, 4'd3);
		run_phase(60, 30, 40, 6);

		// random mid-range setting
		configure(WORD_W'($urandom_range(64, 200)), STROBE_W'($urandom_range(0, 15)),
			STROBE_W'($urandom_range(0, 15)));
		run_phase(80, 20, 10, 15);

		// gap-free tail at the shortest period and strobes
		configure(32'd64, 4'd1, 4'd1);
		quiet_tail = 1'b1;
		send_tick(1'b0, 1'b0, 16'h0000);
		for (int i = 0; i < HAUL_TICKS; i++)
			send_tick(1'b1, ((i / 8) % 2) == 0, BUS_W'($urandom_range(0, 16'hFFFF)));
		wait_drained();
		repeat (3) @(negedge clk);

		$display("covered %0d ticks over %0d register settings, incl. long output hold",
			ticks_checked, settings_used);
		$display("%0d store writes and %0d buffer completions compared",
			store_writes, completions);
		if (mismatches == 0)
			$display("** parallel_adc_multichannel_capture: PASSED **");
		else
			$display("** parallel_adc_multichannel_capture: FAILED **");
		$finish;
	end

endmodule
